FILE: hw/rtl/slu_pkg.sv
// types, codes and widths shared by the line stepper
package slu_pkg;

   localparam int COORD_BITS = 11;
   localparam int RISE_BITS  = COORD_BITS + 1;
   localparam int ERR_BITS   = 2 * COORD_BITS + 2;

   localparam logic       OP_TICK  = 1'b0;
   localparam logic       OP_START = 1'b1;

   localparam logic [1:0] ST_PIXEL  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_ACCEPT = 2'd2;
   localparam logic [1:0] ST_REJECT = 2'd3;

   localparam logic [1:0] DIR_FLAT = 2'd0;
   localparam logic [1:0] DIR_RISE = 2'd1;
   localparam logic [1:0] DIR_FALL = 2'd2;

   typedef struct packed {
      logic                  op;
      logic [COORD_BITS-1:0] x_start;
      logic [COORD_BITS-1:0] y_start;
      logic [COORD_BITS-1:0] x_end;
      logic [COORD_BITS-1:0] y_end;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic                  last;
   } rsp_type;

   typedef struct packed {
      logic    vld;
      req_type word;
   } stage_type;

endpackage

FILE: hw/rtl/slope_compare_line_stepper_unit.sv
// line stepper top level: input register, walk step and result register
//
//   channel   dir   payload            handshake
//   req       in    slu_pkg::req_type  req_valid / req_stall
//   rsp       out   slu_pkg::rsp_type  rsp_valid / rsp_stall
//
// one word per clock sustained while rsp_stall is low, each word gives exactly one result word
// each word passes the input register, then the step logic into the result register
// the line state moves when a word passes from the input register to the result register
// synchronous reset clears the line state and both valid flags
// rsp_stall holds the result register; req_stall rises once the input register is also full
module slope_compare_line_stepper_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  slu_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output slu_pkg::rsp_type rsp_data
);
   import slu_pkg::*;

   stage_type stage;
   rsp_type   step_rsp;
   logic      out_free;
   logic      take;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff, rsp_data_in;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign take     = stage.vld && out_free;

   slu_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .take      (take),
      .stage     (stage)
   );

   slu_walk u_walk (
      .clock   (clock),
      .reset   (reset),
      .step_en (take),
      .word    (stage.word),
      .result  (step_rsp)
   );

   assign rsp_valid_in = take || (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = take ? step_rsp : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> stage.vld)
      else $error("req_stall raised with an empty input register");

   a_held_word_kept : assert property (@(posedge clock) disable iff (reset)
      (stage.vld && !out_free) |=> stage.vld)
      else $error("input word lost while the result register was blocked");

   a_no_pixel_fields_clear : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_PIXEL)
         |-> (rsp_data.pixel_x == '0 && rsp_data.pixel_y == '0 && !rsp_data.last))
      else $error("non-pixel result carries pixel fields");

endmodule

FILE: hw/rtl/slu_in_reg.sv
// input register stage of the line stepper
module slu_in_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  slu_pkg::req_type req_data,
   input  logic             take,
   output slu_pkg::stage_type stage
);
   import slu_pkg::*;

   logic    vld_ff;
   logic    vld_in;
   req_type word_ff;
   req_type word_in;
   logic    load;

   assign req_stall = vld_ff && !take;
   assign load      = req_valid && !req_stall;

   always_comb begin
      vld_in  = vld_ff;
      word_in = word_ff;
      if (load) begin
         vld_in  = 1'b1;
         word_in = req_data;
      end else if (take) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      word_ff <= word_in;
   end

   assign stage.vld  = vld_ff;
   assign stage.word = word_ff;

endmodule

FILE: hw/rtl/slu_walk.sv
// line state and single step logic with incremental slope error
module slu_walk (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  slu_pkg::req_type word,
   output slu_pkg::rsp_type result
);
   import slu_pkg::*;

   logic [COORD_BITS-1:0]       cur_col_ff, cur_col_in;
   logic [COORD_BITS-1:0]       cur_row_ff, cur_row_in;
   logic [COORD_BITS-1:0]       target_col_ff, target_col_in;
   logic [COORD_BITS-1:0]       target_row_ff, target_row_in;
   logic [COORD_BITS-1:0]       run_end_ff, run_end_in;
   logic signed [RISE_BITS-1:0] rise_end_ff, rise_end_in;
   logic signed [ERR_BITS-1:0]  err_ff, err_in;
   logic [1:0]                  direction_ff, direction_in;
   logic                        active_ff, active_in;
   logic                        first_step_ff, first_step_in;

   logic signed [ERR_BITS-1:0]  run_ext;
   logic signed [ERR_BITS-1:0]  rise_ext;
   logic signed [RISE_BITS-1:0] rise_new;
   logic                        reject;
   logic [1:0]                  dir_new;
   logic                        col_step;
   logic                        last;

   assign run_ext  = $signed({{(ERR_BITS - COORD_BITS){1'b0}}, run_end_ff});
   assign rise_ext = $signed({{(ERR_BITS - RISE_BITS){rise_end_ff[RISE_BITS-1]}},
                              rise_end_ff});
   assign rise_new = $signed({1'b0, word.y_end}) - $signed({1'b0, word.y_start});
   assign reject   = (word.x_end < word.x_start)
                     || ((word.x_end == word.x_start) && (word.y_end != word.y_start));

   always_comb begin
      if (word.y_end < word.y_start) begin
         dir_new = DIR_RISE;
      end else if (word.y_end > word.y_start) begin
         dir_new = DIR_FALL;
      end else begin
         dir_new = DIR_FLAT;
      end
   end

   // rising walks in x while error <= 0, falling while error >= 0
   always_comb begin
      case (direction_ff)
         DIR_RISE: col_step = (err_ff <= 0);
         DIR_FALL: col_step = (err_ff >= 0);
         default:  col_step = 1'b1;
      endcase
   end

   always_comb begin
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      target_col_in = target_col_ff;
      target_row_in = target_row_ff;
      run_end_in    = run_end_ff;
      rise_end_in   = rise_end_ff;
      err_in        = err_ff;
      direction_in  = direction_ff;
      active_in     = active_ff;
      first_step_in = first_step_ff;
      result        = '0;
      last          = 1'b0;
      if (word.op == OP_START) begin
         active_in = 1'b0;
         if (reject) begin
            result.status = ST_REJECT;
         end else begin
            result.status = ST_ACCEPT;
            cur_col_in    = word.x_start;
            cur_row_in    = word.y_start;
            target_col_in = word.x_end;
            target_row_in = word.y_end;
            run_end_in    = word.x_end - word.x_start;
            rise_end_in   = rise_new;
            err_in        = '0;
            direction_in  = dir_new;
            first_step_in = (dir_new != DIR_FLAT);
            active_in     = (word.x_end != word.x_start);
         end
      end else if (!active_ff) begin
         result.status = ST_IDLE;
      end else begin
         if (direction_ff != DIR_RISE && direction_ff != DIR_FALL) begin
            cur_col_in = cur_col_ff + 1'b1;
         end else if (first_step_ff) begin
            cur_col_in    = cur_col_ff + 1'b1;
            first_step_in = 1'b0;
            if (direction_ff == DIR_RISE) begin
               cur_row_in = cur_row_ff - 1'b1;
               err_in     = err_ff - rise_ext - run_ext;
            end else begin
               cur_row_in = cur_row_ff + 1'b1;
               err_in     = err_ff - rise_ext + run_ext;
            end
         end else if (col_step) begin
            cur_col_in = cur_col_ff + 1'b1;
            err_in     = err_ff - rise_ext;
         end else if (direction_ff == DIR_RISE) begin
            cur_row_in = cur_row_ff - 1'b1;
            err_in     = err_ff - run_ext;
         end else begin
            cur_row_in = cur_row_ff + 1'b1;
            err_in     = err_ff + run_ext;
         end
         last = (cur_col_in == target_col_ff) && (cur_row_in == target_row_ff);
         if (last) begin
            active_in = 1'b0;
         end
         result.status  = ST_PIXEL;
         result.pixel_x = cur_col_in;
         result.pixel_y = cur_row_in;
         result.last    = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff    <= '0;
         cur_row_ff    <= '0;
         target_col_ff <= '0;
         target_row_ff <= '0;
         run_end_ff    <= '0;
         rise_end_ff   <= '0;
         err_ff        <= '0;
         direction_ff  <= DIR_FLAT;
         active_ff     <= 1'b0;
         first_step_ff <= 1'b0;
      end else if (step_en) begin
         cur_col_ff    <= cur_col_in;
         cur_row_ff    <= cur_row_in;
         target_col_ff <= target_col_in;
         target_row_ff <= target_row_in;
         run_end_ff    <= run_end_in;
         rise_end_ff   <= rise_end_in;
         err_ff        <= err_in;
         direction_ff  <= direction_in;
         active_ff     <= active_in;
         first_step_ff <= first_step_in;
      end
   end

endmodule
